FILE: rtl/isbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package isbt_pkg;
	localparam int KindW = 3;
	localparam int AddrW = 32;
	localparam int AmtW = 8;
	localparam int TimeW = 64;
	localparam int ToW = 40;
	localparam int CntW = 11;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 40;

	localparam logic [KindW-1:0] KIND_STRIKE = 3'd0;
	localparam logic [KindW-1:0] KIND_LOOKUP = 3'd1;
	localparam logic [KindW-1:0] KIND_REMOVE = 3'd2;
	localparam logic [KindW-1:0] KIND_CLEAR = 3'd3;
	localparam logic [KindW-1:0] KIND_CLEANUP = 3'd4;

	localparam logic [CfgIdxW-1:0] REG_STRIKE_LIMIT = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_STRIKE_TO = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_BLOCK_TO = 2'd2;

	localparam logic [AmtW-1:0] STRIKE_CEILING = 8'd255;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [AddrW-1:0] ip_address;
		logic [AmtW-1:0] strike_amount;
		logic [TimeW-1:0] time_now;
	} req_t;

	typedef struct packed {
		logic found;
		logic is_blocked_now;
		logic newly_blocked;
		logic [AmtW-1:0] strike_total;
		logic dropped;
		logic [CntW-1:0] removed_count;
		logic [CntW-1:0] entries_used;
		logic [CntW-1:0] blocked_total;
	} rsp_t;

	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic [AmtW-1:0] strikes;
		logic blocked;
		logic [TimeW-1:0] last_time;
	} slot_t;
endpackage
`default_nettype wire

FILE: rtl/isbt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface isbt_req_if;
	import isbt_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface isbt_rsp_if;
	import isbt_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/ip_strike_blacklist_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Strike blacklist table of TABLE_DEPTH IPv4 entries in one synchronous memory
// (one read, one write port, read data registered). One operation at a time:
// a search pass issues a read and then compares, entry by entry;
// a removal compacts by copying each later entry down one slot (read, then write);
// cleanup walks from the last entry down, compacting behind each expiry.
// A strike that evicts from a full table runs a full search, an eviction search
// and a compaction. The result register frees the engine once loaded.
module ip_strike_blacklist_table_core #(
	parameter int TABLE_DEPTH = 32
) (
	input wire clk,
	input wire arst_n,
	isbt_req_if.sink req,
	isbt_rsp_if.source rsp,
	input wire cfg_we,
	input wire [isbt_pkg::CfgIdxW-1:0] cfg_index,
	input wire [isbt_pkg::CfgDataW-1:0] cfg_data
);
	import isbt_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int UW = $clog2(TABLE_DEPTH + 1);
	localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SRCH = 4'd1; // issue read
	localparam logic [3:0] ST_SCMP = 4'd2; // compare read data
	localparam logic [3:0] ST_SHRD = 4'd3; // compaction read
	localparam logic [3:0] ST_SHWR = 4'd4; // compaction write
	localparam logic [3:0] ST_APND = 4'd5;
	localparam logic [3:0] ST_CRD = 4'd6;
	localparam logic [3:0] ST_CCMP = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;
	localparam logic [3:0] ST_EVRD = 4'd9; // eviction search read
	localparam logic [3:0] ST_EVCMP = 4'd10;

	slot_t mem [TABLE_DEPTH];
	slot_t rd_q;
	logic mem_we;
	logic [IW-1:0] wa, ra;
	slot_t wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	logic [3:0] st_q, st_d;
	req_t r_q;
	logic [UW-1:0] used_q, blk_q, i_q, j_q, rem_q;
	logic found_q, blkn_q, newly_q, drop_q;
	logic [AmtW-1:0] tot_q;
	logic [3:0] ret_q; // state after compaction
	logic [AmtW-1:0] lim_q;
	logic [ToW-1:0] sto_q, bto_q;
	logic ov_q;
	rsp_t out_q;

	assign req.ready = (st_q == ST_IDLE);
	assign rsp.valid = ov_q;
	assign rsp.payload = out_q;

	logic [AmtW:0] sum;
	logic [TimeW-1:0] age;
	logic expire;
	assign sum = {1'b0, rd_q.strikes} + {1'b0, r_q.strike_amount};
	assign age = r_q.time_now - rd_q.last_time;
	assign expire = rd_q.blocked ? (age > {24'd0, bto_q}) : (age > {24'd0, sto_q});

	always_comb begin
		ra = i_q[IW-1:0];
		if (st_q == ST_SHRD) begin
			ra = IW'(j_q + UW'(1));
		end else if (st_q == ST_CRD) begin
			ra = IW'(i_q - UW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= 8'd5;
			sto_q <= 40'd3600000000;
			bto_q <= 40'd86400000000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRIKE_LIMIT: lim_q <= cfg_data[AmtW-1:0];
				REG_STRIKE_TO: sto_q <= cfg_data;
				REG_BLOCK_TO: bto_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		mem_we = 1'b0;
		wa = j_q[IW-1:0];
		wd = rd_q;
		if (st_q == ST_SHWR) begin
			mem_we = 1'b1;
		end else if (st_q == ST_SCMP && r_q.kind == KIND_STRIKE
				&& rd_q.addr == r_q.ip_address && !rd_q.blocked) begin
			mem_we = 1'b1;
			wa = i_q[IW-1:0];
			wd.strikes = sum[AmtW] ? STRIKE_CEILING : sum[AmtW-1:0];
			wd.last_time = r_q.time_now;
			wd.blocked = (sum[AmtW] ? STRIKE_CEILING : sum[AmtW-1:0]) >= lim_q;
		end else if (st_q == ST_APND) begin
			mem_we = 1'b1;
			wa = used_q[IW-1:0];
			wd.addr = r_q.ip_address;
			wd.strikes = r_q.strike_amount;
			wd.blocked = r_q.strike_amount >= lim_q;
			wd.last_time = r_q.time_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			used_q <= '0;
			blk_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (rsp.ready && st_q != ST_DONE) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (req.valid) begin
						r_q <= req.payload;
						found_q <= 1'b0;
						blkn_q <= 1'b0;
						newly_q <= 1'b0;
						drop_q <= 1'b0;
						tot_q <= '0;
						rem_q <= '0;
						i_q <= '0;
						unique case (req.payload.kind)
							KIND_STRIKE, KIND_LOOKUP, KIND_REMOVE: st_q <= ST_SRCH;
							KIND_CLEAR: begin
								rem_q <= used_q;
								used_q <= '0;
								blk_q <= '0;
								st_q <= ST_DONE;
							end
							KIND_CLEANUP: begin
								i_q <= used_q;
								st_q <= ST_CRD;
							end
							default: st_q <= ST_DONE;
						endcase
					end
				end
				ST_SRCH: begin
					if (i_q >= used_q) begin
						if (r_q.kind != KIND_STRIKE) begin
							st_q <= ST_DONE;
						end else if (used_q >= DEPTH_U) begin
							i_q <= '0;
							st_q <= ST_EVRD;
						end else begin
							st_q <= ST_APND;
						end
					end else begin
						st_q <= ST_SCMP;
					end
				end
				ST_SCMP: begin
					if (rd_q.addr == r_q.ip_address) begin
						found_q <= 1'b1;
						st_q <= ST_DONE;
						if (r_q.kind == KIND_STRIKE) begin
							blkn_q <= wd.blocked;
							tot_q <= wd.strikes;
							if (!rd_q.blocked && wd.blocked) begin
								newly_q <= 1'b1;
								blk_q <= blk_q + UW'(1);
							end
						end else if (r_q.kind == KIND_LOOKUP) begin
							blkn_q <= rd_q.blocked;
							tot_q <= rd_q.strikes;
						end else begin
							rem_q <= UW'(1);
							if (rd_q.blocked) begin
								blk_q <= blk_q - UW'(1);
							end
							j_q <= i_q;
							ret_q <= ST_DONE;
							st_q <= ST_SHRD;
						end
					end else begin
						i_q <= i_q + UW'(1);
						st_q <= ST_SRCH;
					end
				end
				ST_EVRD: begin
					if (i_q >= used_q) begin
						drop_q <= 1'b1;
						st_q <= ST_DONE;
					end else begin
						st_q <= ST_EVCMP;
					end
				end
				ST_EVCMP: begin
					if (!rd_q.blocked) begin
						j_q <= i_q;
						ret_q <= ST_APND;
						st_q <= ST_SHRD;
					end else begin
						i_q <= i_q + UW'(1);
						st_q <= ST_EVRD;
					end
				end
				ST_SHRD: begin
					if (j_q + UW'(1) >= used_q) begin
						used_q <= used_q - UW'(1);
						st_q <= ret_q;
					end else begin
						st_q <= ST_SHWR;
					end
				end
				ST_SHWR: begin
					j_q <= j_q + UW'(1);
					st_q <= ST_SHRD;
				end
				ST_APND: begin
					found_q <= 1'b0;
					blkn_q <= wd.blocked;
					newly_q <= wd.blocked;
					tot_q <= r_q.strike_amount;
					used_q <= used_q + UW'(1);
					if (wd.blocked) begin
						blk_q <= blk_q + UW'(1);
					end
					st_q <= ST_DONE;
				end
				ST_CRD: begin
					if (i_q == '0) begin
						st_q <= ST_DONE;
					end else begin
						i_q <= i_q - UW'(1);
						st_q <= ST_CCMP;
					end
				end
				ST_CCMP: begin
					if (expire) begin
						rem_q <= rem_q + UW'(1);
						if (rd_q.blocked) begin
							blk_q <= blk_q - UW'(1);
						end
						j_q <= i_q;
						ret_q <= ST_CRD;
						st_q <= ST_SHRD;
					end else begin
						st_q <= ST_CRD;
					end
				end
				ST_DONE: begin
					if (!ov_q || rsp.ready) begin
						ov_q <= 1'b1;
						out_q.found <= found_q;
						out_q.is_blocked_now <= blkn_q;
						out_q.newly_blocked <= newly_q;
						out_q.strike_total <= tot_q;
						out_q.dropped <= drop_q;
						out_q.removed_count <= CntW'(rem_q);
						out_q.entries_used <= CntW'(used_q);
						out_q.blocked_total <= CntW'(blk_q);
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
